// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while rst_n is low.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent |=> consequent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

    localparam int DEF_MAP_BYTES = 512;
    localparam int DEF_MAP_PAGES = 1;

    // Memory word: 64 map bits (eight map bytes) per entry; same width for the summary.
    localparam int WORD_BITS = 64;
    localparam int POS_W     = 6;

    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } lz_t;

    // Lowest clear bit of a word, counting from bit 0.
    function automatic lz_t lowest_zero(input logic [WORD_BITS-1:0] w);
        lz_t r;
        r.found = 1'b0;
        r.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r.found = 1'b1;
                r.pos   = POS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/block_bitmap_allocator_unit.sv =====
// First-fit block allocator over an occupancy bitmap (1 = block in use).
// Request channel (req_valid/req_ready): opcode 0 allocates the lowest free
// block, opcode 1 frees block_index. Response channel (rsp_valid/rsp_ready):
// one response per request, granted_index and status (done, full, bad index).
// One request is in flight at a time; req_ready is high while the sequencer
// is idle, also while a finished response waits in the output register.
// A plain allocate or free passes through the update and done steps; an
// allocate that fills a 64-block word or a free that hits a full word
// adds a summary read-modify-write step, and after a fill one scan step
// per further summary entry read while searching for the next non-full
// word; an allocate on a full map or a free with a bad index goes straight
// to the done step. The next request is taken the cycle after a response
// is loaded. The summary memory holds one full-flag per 64-block word.
// Registered memory reads set the step.
// Reset: the bitmap reads as all free at once; a high-water mark of touched
// words masks never-written memory contents, so there is no clearing pass.
// A stalled receiver holds the response in the output register; the
// sequencer waits in its final step until that register is free.

`include "assert_macros.svh"

`default_nettype none

module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = DEF_MAP_BYTES,
    parameter int MAP_PAGES = DEF_MAP_PAGES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                opcode,
    input  wire logic [INDEX_W-1:0]  block_index,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [INDEX_W-1:0]       granted_index,
    output logic [STATUS_W-1:0]      status
);

    localparam int TOTAL_BYTES = MAP_BYTES * MAP_PAGES;
    localparam int TOTAL_BITS  = TOTAL_BYTES * 8;
    localparam int WORDS       = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_WORDS   = (WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int HW          = $clog2(WORDS + 1);
    localparam int SAW         = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int PAD_BITS    = WORDS * WORD_BITS - TOTAL_BITS;
    localparam int SUM_PAD     = SUM_WORDS * WORD_BITS - WORDS;

    localparam logic [WORD_BITS-1:0] LAST_PAD_MASK = ~({WORD_BITS{1'b1}} >> PAD_BITS);
    localparam logic [WORD_BITS-1:0] SUM_PAD_MASK  = ~({WORD_BITS{1'b1}} >> SUM_PAD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_SUMA = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_SUMF = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [WORD_BITS-1:0] data_mem [WORDS];
    logic [WORD_BITS-1:0] sum_mem  [SUM_WORDS];

    logic [2:0]           state_reg, state_next;
    logic                 op_reg, op_next;
    logic [WAW-1:0]       word_reg, word_next;
    logic [POS_W-1:0]     bit_reg, bit_next;
    logic [SAW-1:0]       entry_reg, entry_next;
    logic [HW-1:0]        hint_reg, hint_next;
    logic [HW-1:0]        hwm_reg, hwm_next;
    logic [INDEX_W-1:0]   res_idx_reg, res_idx_next;
    logic [STATUS_W-1:0]  res_st_reg, res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   out_idx_reg, out_idx_next;
    logic [STATUS_W-1:0]  out_st_reg, out_st_next;
    logic [WORD_BITS-1:0] dm_q_reg;
    logic [WORD_BITS-1:0] sm_q_reg;

    logic                 dm_rd_en, dm_wr_en, sm_rd_en, sm_wr_en;
    logic [WAW-1:0]       dm_rd_addr;
    logic [SAW-1:0]       sm_rd_addr;
    logic [WORD_BITS-1:0] dm_wr_data, sm_wr_data;

    logic                 req_xfer;
    logic [31:0]          free_word_w;
    logic [31:0]          word_w;
    logic [31:0]          hwm_w;
    logic [31:0]          entry_w;
    logic [31:0]          hwm_entry_w;
    logic                 word_touched;
    logic [WORD_BITS-1:0] word_pad;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    lz_t                  word_lz;
    logic [WORD_BITS-1:0] sum_mask;
    logic [WORD_BITS-1:0] sum_pad;
    logic [WORD_BITS-1:0] cur_sum;
    logic [WORD_BITS-1:0] sbit_mask;
    logic [WORD_BITS-1:0] scan_sum;
    lz_t                  sum_lz;
    logic [31:0]          blk_w;
    logic [31:0]          found_word_w;
    logic                 last_entry;

    assign req_xfer = req_valid && req_ready;

    assign free_word_w  = 32'(block_index) >> POS_W;
    assign word_w       = 32'(word_reg);
    assign hwm_w        = 32'(hwm_reg);
    assign entry_w      = 32'(entry_reg);
    assign hwm_entry_w  = hwm_w >> POS_W;

    // Words at or above the high-water mark were never written: they read as free.
    assign word_touched = word_w < hwm_w;
    assign word_pad     = (word_w == 32'(WORDS - 1)) ? LAST_PAD_MASK : '0;
    assign cur_word     = word_touched ? dm_q_reg : '0;
    assign word_lz      = lowest_zero(cur_word | word_pad);
    assign set_word     = cur_word | (64'h1 << word_lz.pos);
    assign clr_word     = cur_word & ~(64'h1 << bit_reg);

    always_comb
    begin
        if (entry_w < hwm_entry_w)
            sum_mask = '1;
        else if (entry_w == hwm_entry_w)
            sum_mask = (64'h1 << hwm_w[POS_W-1:0]) - 64'h1;
        else
            sum_mask = '0;
    end

    assign last_entry   = entry_w == 32'(SUM_WORDS - 1);
    assign sum_pad      = last_entry ? SUM_PAD_MASK : '0;
    assign cur_sum      = sm_q_reg & sum_mask;
    assign sbit_mask    = 64'h1 << word_w[POS_W-1:0];
    assign scan_sum     = (state_reg == S_SUMA) ? (cur_sum | sbit_mask) : cur_sum;
    assign sum_lz       = lowest_zero(scan_sum | sum_pad);
    assign found_word_w = (entry_w << POS_W) | 32'(sum_lz.pos);
    assign blk_w        = (word_w << POS_W) | 32'(word_lz.pos);

    assign req_ready     = state_reg == S_IDLE;
    assign rsp_valid     = out_valid_reg;
    assign granted_index = out_idx_reg;
    assign status        = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        entry_next     = entry_reg;
        hint_next      = hint_reg;
        hwm_next       = hwm_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_st_next    = out_st_reg;
        dm_rd_en       = 1'b0;
        dm_rd_addr     = hint_reg[WAW-1:0];
        dm_wr_en       = 1'b0;
        dm_wr_data     = set_word;
        sm_rd_en       = 1'b0;
        sm_rd_addr     = SAW'(word_w >> POS_W);
        sm_wr_en       = 1'b0;
        sm_wr_data     = cur_sum | sbit_mask;

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next      = opcode;
                    res_idx_next = '0;
                    res_st_next  = STAT_DONE;
                    if (opcode == OP_ALLOC)
                    begin
                        word_next = hint_reg[WAW-1:0];
                        if (32'(hint_reg) == 32'(WORDS))
                        begin
                            res_st_next = STAT_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            dm_rd_en   = 1'b1;
                            dm_rd_addr = hint_reg[WAW-1:0];
                            state_next = S_UPD;
                        end
                    end
                    else
                    begin
                        word_next = free_word_w[WAW-1:0];
                        bit_next  = block_index[POS_W-1:0];
                        if (32'(block_index) >= 32'(TOTAL_BITS))
                        begin
                            res_st_next = STAT_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            dm_rd_en   = 1'b1;
                            dm_rd_addr = free_word_w[WAW-1:0];
                            state_next = S_UPD;
                        end
                    end
                end
            end

            S_UPD:
            begin
                entry_next = SAW'(word_w >> POS_W);
                if (op_reg == OP_ALLOC)
                begin
                    dm_wr_en     = 1'b1;
                    dm_wr_data   = set_word;
                    res_idx_next = blk_w[INDEX_W-1:0];
                    if (!word_touched)
                        hwm_next = HW'(word_w + 32'd1);
                    if (&(set_word | word_pad))
                    begin
                        sm_rd_en   = 1'b1;
                        state_next = S_SUMA;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    dm_wr_en   = word_touched;
                    dm_wr_data = clr_word;
                    if (word_w < 32'(hint_reg))
                        hint_next = HW'(word_w);
                    if (word_touched && (&(cur_word | word_pad)))
                    begin
                        sm_rd_en   = 1'b1;
                        state_next = S_SUMF;
                    end
                    else
                        state_next = S_DONE;
                end
            end

            S_SUMA, S_SCAN:
            begin
                if (state_reg == S_SUMA)
                begin
                    sm_wr_en   = 1'b1;
                    sm_wr_data = cur_sum | sbit_mask;
                end
                if (sum_lz.found)
                begin
                    hint_next  = HW'(found_word_w);
                    state_next = S_DONE;
                end
                else if (last_entry)
                begin
                    hint_next  = HW'(WORDS);
                    state_next = S_DONE;
                end
                else
                begin
                    entry_next = SAW'(entry_w + 32'd1);
                    sm_rd_en   = 1'b1;
                    sm_rd_addr = SAW'(entry_w + 32'd1);
                    state_next = S_SCAN;
                end
            end

            S_SUMF:
            begin
                sm_wr_en   = 1'b1;
                sm_wr_data = cur_sum & ~sbit_mask;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            hwm_reg       <= hwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        word_reg    <= word_next;
        bit_reg     <= bit_next;
        entry_reg   <= entry_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        out_idx_reg <= out_idx_next;
        out_st_reg  <= out_st_next;
    end

    // Bitmap words; read and write never hit one entry in the same cycle
    // since the sequencer reads, then writes back one step later.
    always_ff @(posedge clk)
    begin
        if (dm_wr_en)
            data_mem[word_reg] <= dm_wr_data;
        if (dm_rd_en)
            dm_q_reg <= data_mem[dm_rd_addr];
    end

    // One full-flag per bitmap word.
    always_ff @(posedge clk)
    begin
        if (sm_wr_en)
            sum_mem[entry_reg] <= sm_wr_data;
        if (sm_rd_en)
            sm_q_reg <= sum_mem[sm_rd_addr];
    end

    `CHK_ALWAYS(a_hint_bound, 32'(hint_reg) <= 32'(WORDS), "hint beyond map")
    `CHK_ALWAYS(a_hint_below_hwm, hint_reg <= hwm_reg, "hint above high-water mark")
    `CHK_NEXT(a_hwm_monotone, 1'b1, hwm_reg >= $past(hwm_reg), "high-water mark fell")
    `CHK_NEXT(a_busy_after_req, req_xfer, state_reg != S_IDLE, "request transfer not taken up")

endmodule

`default_nettype wire
